// ===== hdl/rrt_pkg.sv =====
// rrt_pkg: shared types and constants of the received range tracker
// interval record, result bundle and command codes; no dependencies

package rrt_pkg;

	localparam int MAX_INTERVALS_DEF = 16;
	localparam int WORD_W = 64;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t lo;
		word_t hi;
	} ival_t;

	typedef struct packed {
		logic all_received;
		logic covered;
		logic table_full;
	} res_t;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

endpackage

// ===== hdl/received_range_tracker.sv =====
// received_range_tracker: top level with size register and result output register
// depends on rrt_pkg, rrt_ctrl and rrt_mem
// add: scan, then entry placement and tail move, then head read
// query and dropped add: scan then head read; inverted range: head read only
// one item at a time, next transfer in the cycle after the result leaves, which may still wait
// reset clears the size register, the interval count and the sequencer; table contents stay

module received_range_tracker #(
	parameter int MAX_INTERVALS = rrt_pkg::MAX_INTERVALS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  rrt_pkg::word_t      range_start,
	input  rrt_pkg::word_t      range_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                all_received,
	output logic                covered,
	output logic                table_full,
	input  logic                cfg_wr_en,
	input  rrt_pkg::word_t      cfg_wr_data
);
	import rrt_pkg::*;

	localparam int AW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);

	word_t         object_size_q;
	logic          out_valid_q;
	res_t          out_q;
	logic          res_valid, res_ready;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	ival_t         mem_wdata, mem_rdata;

	rrt_ctrl #(
		.MAX_INTERVALS(MAX_INTERVALS),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_cmd     (cmd),
		.in_start   (range_start),
		.in_end     (range_end),
		.object_size(object_size_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	rrt_mem #(
		.DEPTH(MAX_INTERVALS),
		.AW(AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output slot frees on the same edge as its transfer
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_size_q <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				object_size_q <= cfg_wr_data;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
				if (res_valid) begin
					out_q <= res;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign all_received = out_q.all_received;
	assign covered      = out_q.covered;
	assign table_full   = out_q.table_full;

endmodule

// ===== hdl/rrt_mem.sv =====
// rrt_mem: interval table storage, one write port and one registered read port
// depends on rrt_pkg for the interval record type

module rrt_mem #(
	parameter int DEPTH = rrt_pkg::MAX_INTERVALS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rrt_pkg::ival_t wdata,
	input  logic [AW-1:0] raddr,
	output rrt_pkg::ival_t rdata
);
	import rrt_pkg::*;

	ival_t mem_q [DEPTH];
	ival_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/rrt_ctrl.sv =====
// rrt_ctrl: sequencer that scans, merges and compacts the interval table
// depends on rrt_pkg; drives the ports of rrt_mem

module rrt_ctrl #(
	parameter int MAX_INTERVALS = rrt_pkg::MAX_INTERVALS_DEF,
	parameter int AW = $clog2(MAX_INTERVALS),
	parameter int CW = $clog2(MAX_INTERVALS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_cmd,
	input  rrt_pkg::word_t in_start,
	input  rrt_pkg::word_t in_end,
	input  rrt_pkg::word_t object_size,
	output logic           res_valid,
	input  logic           res_ready,
	output rrt_pkg::res_t  res,
	output logic           mem_we,
	output logic [AW-1:0]  mem_waddr,
	output rrt_pkg::ival_t mem_wdata,
	output logic [AW-1:0]  mem_raddr,
	input  rrt_pkg::ival_t mem_rdata
);
	import rrt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_MOVE,
		ST_HEAD_RD,
		ST_HEAD_EV,
		ST_RESULT
	} state_t;

	state_t        state_q;
	logic          cmd_q;
	word_t         s_q, e_q, s_m1_q, e_p1_q, ns_q, ne_q;
	logic          s_zero_q, e_max_q;
	logic [CW-1:0] count_q, k_q, pos_q, rd_idx_q, mv_left_q, ridx_s1;
	logic          pos_found_q, place_after_q, rv_s1;
	logic          covered_q, full_q, all_q;

	logic          left_ok, right_ok, touch, contains, after;
	logic          rd_issue, mv_issue;
	logic [CW-1:0] pos_eff, dest;

	always_comb begin
		left_ok  = e_max_q || (mem_rdata.lo <= e_p1_q);
		right_ok = s_zero_q || (s_m1_q <= mem_rdata.hi);
		touch    = left_ok && right_ok;
		contains = (mem_rdata.lo <= s_q) && (e_q <= mem_rdata.hi);
		after    = mem_rdata.lo > e_q;
		rd_issue = rd_idx_q != count_q;
		mv_issue = mv_left_q != '0;
		pos_eff  = pos_found_q ? pos_q : count_q;
		dest     = ridx_s1 - k_q + CW'(1);
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = '{lo: ns_q, hi: ne_q};
		mem_raddr = rd_idx_q[AW-1:0];
		unique case (state_q)
			ST_PLACE: begin
				mem_we = 1'b1;
			end
			ST_MOVE: begin
				mem_we    = rv_s1;
				mem_waddr = dest[AW-1:0];
				mem_wdata = mem_rdata;
			end
			ST_HEAD_RD: begin
				mem_raddr = '0;
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = state_q == ST_IDLE;
	assign res_valid = state_q == ST_RESULT;
	assign res       = '{all_received: all_q, covered: covered_q, table_full: full_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			rv_s1         <= 1'b0;
			cmd_q         <= CMD_ADD;
			s_q           <= '0;
			e_q           <= '0;
			s_m1_q        <= '0;
			e_p1_q        <= '0;
			ns_q          <= '0;
			ne_q          <= '0;
			s_zero_q      <= 1'b0;
			e_max_q       <= 1'b0;
			k_q           <= '0;
			pos_q         <= '0;
			rd_idx_q      <= '0;
			mv_left_q     <= '0;
			ridx_s1       <= '0;
			pos_found_q   <= 1'b0;
			place_after_q <= 1'b0;
			covered_q     <= 1'b0;
			full_q        <= 1'b0;
			all_q         <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q       <= in_cmd;
						s_q         <= in_start;
						e_q         <= in_end;
						s_m1_q      <= in_start - word_t'(1);
						e_p1_q      <= in_end + word_t'(1);
						s_zero_q    <= in_start == '0;
						e_max_q     <= in_end == '1;
						ns_q        <= in_start;
						ne_q        <= in_end;
						k_q         <= '0;
						pos_q       <= '0;
						pos_found_q <= 1'b0;
						covered_q   <= 1'b0;
						full_q      <= 1'b0;
						rd_idx_q    <= '0;
						rv_s1       <= 1'b0;
						state_q     <= (in_start > in_end) ? ST_HEAD_RD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rv_s1   <= rd_issue;
					ridx_s1 <= rd_idx_q;
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (rv_s1) begin
						if (touch) begin
							k_q <= k_q + CW'(1);
							if (mem_rdata.lo < ns_q) begin
								ns_q <= mem_rdata.lo;
							end
							if (mem_rdata.hi > ne_q) begin
								ne_q <= mem_rdata.hi;
							end
						end
						if (!pos_found_q && (touch || after)) begin
							pos_q       <= ridx_s1;
							pos_found_q <= 1'b1;
						end
						if (contains && cmd_q == CMD_QUERY) begin
							covered_q <= 1'b1;
						end
					end
					if (!rv_s1 && !rd_issue) begin
						pos_q <= pos_eff;
						if (cmd_q == CMD_QUERY) begin
							state_q <= ST_HEAD_RD;
						end else if (k_q == '0 && count_q == CW'(MAX_INTERVALS)) begin
							full_q  <= 1'b1;
							state_q <= ST_HEAD_RD;
						end else if (k_q != '0) begin
							// merged entry goes first, the tail then moves down
							count_q       <= count_q - k_q + CW'(1);
							place_after_q <= 1'b0;
							rd_idx_q      <= pos_eff + k_q;
							mv_left_q     <= count_q - pos_eff - k_q;
							state_q       <= ST_PLACE;
						end else begin
							// tail moves up from the top, then the new entry
							count_q       <= count_q + CW'(1);
							place_after_q <= 1'b1;
							rd_idx_q      <= count_q - CW'(1);
							mv_left_q     <= count_q - pos_eff;
							state_q       <= ST_MOVE;
						end
					end
				end
				ST_PLACE: begin
					rv_s1   <= 1'b0;
					state_q <= place_after_q ? ST_HEAD_RD : ST_MOVE;
				end
				ST_MOVE: begin
					rv_s1   <= mv_issue;
					ridx_s1 <= rd_idx_q;
					if (mv_issue) begin
						rd_idx_q  <= place_after_q ? rd_idx_q - CW'(1) : rd_idx_q + CW'(1);
						mv_left_q <= mv_left_q - CW'(1);
					end
					if (!rv_s1 && !mv_issue) begin
						state_q <= place_after_q ? ST_PLACE : ST_HEAD_RD;
					end
				end
				ST_HEAD_RD: begin
					state_q <= ST_HEAD_EV;
				end
				ST_HEAD_EV: begin
					all_q   <= (count_q == CW'(1)) && (mem_rdata.lo == '0) &&
						(mem_rdata.hi == object_size - word_t'(1));
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_INTERVALS))
		else $error("interval count beyond table depth");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CW'(mem_waddr) < count_q)
		else $error("table write outside the stored intervals");

	a_full_only_at_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.table_full |-> count_q == CW'(MAX_INTERVALS) && cmd_q == CMD_ADD)
		else $error("table full reported with free entries");

	a_covered_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.covered |-> cmd_q == CMD_QUERY)
		else $error("covered reported for an add");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == ST_SCAN)
		else $error("interval count changed outside the scan decision");

endmodule

// ===== tb/range_tracker_checker.sv =====
// range_tracker_checker: watches the item, result and size-register ports of the tracker
// keeps its own interval table, predicts each result and compares it; uses rrt_pkg

module range_tracker_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic           cmd,
	input  rrt_pkg::word_t range_start,
	input  rrt_pkg::word_t range_end,
	input  logic           out_valid,
	input  logic           out_ready,
	input  logic           all_received,
	input  logic           covered,
	input  logic           table_full,
	input  logic           cfg_wr_en,
	input  rrt_pkg::word_t cfg_wr_data,
	output int             fails,
	output int             pending
);
	import rrt_pkg::*;

	localparam int MAX_IV = MAX_INTERVALS_DEF;

	word_t iv_lo [MAX_IV];
	word_t iv_hi [MAX_IV];
	int    iv_n;
	word_t size_q;
	res_t  due_results [$];
	int    mismatches;

	// overlap or adjacency, never wrapping past the top of the offset space
	function automatic bit touching(word_t lo, word_t hi, word_t s, word_t e);
		return (e == '1 || lo <= e + 64'd1) && (hi == '1 || s <= hi + 64'd1);
	endfunction

	function automatic bit merge_range(word_t s, word_t e);
		word_t lo_new [MAX_IV];
		word_t hi_new [MAX_IV];
		word_t ns, ne;
		int    k, n;
		bit    placed;
		if (s > e)
			return 1'b0;
		ns = s;
		ne = e;
		k = 0;
		n = 0;
		placed = 1'b0;
		for (int i = 0; i < iv_n; i++) begin
			if (touching(iv_lo[i], iv_hi[i], s, e)) begin
				k++;
				if (iv_lo[i] < ns)
					ns = iv_lo[i];
				if (iv_hi[i] > ne)
					ne = iv_hi[i];
			end
		end
		if (iv_n - k + 1 > MAX_IV)
			return 1'b1;
		for (int i = 0; i < iv_n; i++) begin
			if (!touching(iv_lo[i], iv_hi[i], s, e)) begin
				if (!placed && iv_lo[i] > ne) begin
					lo_new[n] = ns;
					hi_new[n] = ne;
					n++;
					placed = 1'b1;
				end
				lo_new[n] = iv_lo[i];
				hi_new[n] = iv_hi[i];
				n++;
			end
		end
		if (!placed) begin
			lo_new[n] = ns;
			hi_new[n] = ne;
			n++;
		end
		for (int i = 0; i < n; i++) begin
			iv_lo[i] = lo_new[i];
			iv_hi[i] = hi_new[i];
		end
		iv_n = n;
		return 1'b0;
	endfunction

	function automatic bit range_is_covered(word_t s, word_t e);
		if (s > e)
			return 1'b0;
		for (int i = 0; i < iv_n; i++)
			if (iv_lo[i] <= s && e <= iv_hi[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit whole_object_held();
		return iv_n == 1 && iv_lo[0] == '0 && iv_hi[0] == size_q - 64'd1;
	endfunction

	task automatic note_mismatch(string what, res_t want, res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s: expected done=%0b covered=%0b full=%0b,",
				" got done=%0b covered=%0b full=%0b"},
				what, want.all_received, want.covered, want.table_full,
				got.all_received, got.covered, got.table_full);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want, got;
		if (!arst_n) begin
			iv_n = 0;
			size_q = '0;
			mismatches = 0;
			due_results.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				size_q = cfg_wr_data;
			if (out_valid && out_ready) begin
				got.all_received = all_received;
				got.covered = covered;
				got.table_full = table_full;
				if (due_results.size() == 0) begin
					note_mismatch("result with no item pending", '0, got);
				end else begin
					want = due_results.pop_front();
					if (got.all_received !== want.all_received ||
					    got.covered !== want.covered ||
					    got.table_full !== want.table_full)
						note_mismatch("result mismatch", want, got);
				end
			end
			if (in_valid && in_ready) begin
				want = '0;
				if (cmd == CMD_ADD)
					want.table_full = merge_range(range_start, range_end);
				else
					want.covered = range_is_covered(range_start, range_end);
				want.all_received = whole_object_held();
				due_results = {due_results, want};
			end
			fails <= mismatches;
			pending <= due_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus, handshake timing and verdict for the received range tracker
// depends on rrt_pkg, received_range_tracker and range_tracker_checker

module tb_top;
	import rrt_pkg::*;

	localparam word_t TOP = '1;
	localparam int LIMIT = 400000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	logic  cmd = CMD_ADD;
	word_t range_start = '0;
	word_t range_end = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	logic  all_received;
	logic  covered;
	logic  table_full;
	logic  cfg_wr_en = 1'b0;
	word_t cfg_wr_data = '0;
	int    fails;
	int    pending;
	int    sent = 0;
	int    cycle_count = 0;
	logic  calm;

	assign calm = (sent >= 500 && sent < 620);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	received_range_tracker uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .range_start(range_start), .range_end(range_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.all_received(all_received), .covered(covered), .table_full(table_full),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	range_tracker_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .range_start(range_start), .range_end(range_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.all_received(all_received), .covered(covered), .table_full(table_full),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fails(fails), .pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off while the sender keeps going
	initial begin : result_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sent >= 350) begin
				held = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
			end
		end
	end

	task automatic push_item(logic c, word_t s, word_t e);
		while (!calm && $urandom_range(99) < 27) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		range_start <= s;
		range_end <= e;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	task automatic write_size(word_t v);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		word_t base, size_v, s, e, a, b;
		int    span, w, r;
		logic  c;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, inverted ranges, merging on both sides
		push_item(CMD_QUERY, 64'd0, 64'd0);
		push_item(CMD_ADD, 64'd5, 64'd3);
		push_item(CMD_ADD, 64'd10, 64'd19);
		push_item(CMD_ADD, 64'd30, 64'd39);
		push_item(CMD_ADD, 64'd20, 64'd29);
		push_item(CMD_QUERY, 64'd10, 64'd39);
		push_item(CMD_QUERY, 64'd9, 64'd10);
		push_item(CMD_QUERY, 64'd20, 64'd15);
		push_item(CMD_ADD, 64'd5, 64'd12);
		push_item(CMD_ADD, 64'd35, 64'd50);
		// top of the offset space
		push_item(CMD_ADD, TOP - 64'd3, TOP);
		push_item(CMD_ADD, TOP - 64'd9, TOP - 64'd4);
		push_item(CMD_QUERY, TOP, TOP);
		push_item(CMD_ADD, TOP, TOP);
		push_item(CMD_ADD, TOP - 64'd11, TOP - 64'd11);
		push_item(CMD_QUERY, TOP - 64'd11, TOP);
		push_item(CMD_ADD, 64'd0, 64'd3);
		push_item(CMD_ADD, 64'd4, 64'd4);
		push_item(CMD_QUERY, TOP, 64'd0);
		push_item(CMD_ADD, TOP, 64'd0);
		write_size(64'd51);
		push_item(CMD_QUERY, 64'd0, 64'd50);

		// each phase fills a fresh region above everything below it
		for (int ph = 0; ph < 10; ph++) begin
			base = word_t'(ph + 1) << 20;
			span = $urandom_range(64, 600);
			if (ph == 4)
				size_v = TOP;
			else if (ph % 3 == 2)
				size_v = {$urandom, $urandom};
			else
				size_v = base + word_t'(span);
			write_size(size_v);
			push_item(CMD_ADD, 64'd0, base - 64'd1);
			repeat (85) begin
				r = $urandom_range(99);
				if (r < 62) begin
					w = $urandom_range(1, (ph % 2) ? 4 : span / 6 + 1);
					s = base + word_t'($urandom_range(0, span - 1));
					e = s + word_t'(w - 1);
					if (e > base + word_t'(span - 1))
						e = base + word_t'(span - 1);
					push_item(CMD_ADD, s, e);
				end else if (r < 82) begin
					s = base + word_t'($urandom_range(0, span - 1));
					e = s + word_t'($urandom_range(0, span / 4));
					push_item(CMD_QUERY, s, e);
				end else begin
					c = 1'($urandom_range(1));
					a = {$urandom, $urandom};
					b = {$urandom, $urandom};
					if (c == CMD_ADD && $urandom_range(49) != 0 && a < b)
						push_item(c, b, a);
					else
						push_item(c, a, b);
				end
			end
			push_item(CMD_ADD, 64'd0, base + word_t'(span - 1));
			push_item(CMD_QUERY, base, base + word_t'(span - 1));
		end

		// largest size, then size zero which compares against the top offset
		write_size(TOP);
		push_item(CMD_ADD, 64'd0, TOP - 64'd1);
		push_item(CMD_QUERY, 64'd0, TOP);
		write_size(64'd0);
		push_item(CMD_QUERY, TOP, TOP);
		push_item(CMD_ADD, 64'd7, 64'd7);

		settle();
		if (fails == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/rrt_pkg.sv
hdl/rrt_mem.sv
hdl/rrt_ctrl.sv
hdl/received_range_tracker.sv
tb/range_tracker_checker.sv
tb/tb_top.sv
